FILE: rtl/sname_pkg.sv
package sname_pkg;

  localparam int unsigned ByteW     = 8;
  localparam int unsigned BaseLen   = 8;
  localparam int unsigned ExtLen    = 3;
  localparam int unsigned BaseW     = BaseLen * ByteW;
  localparam int unsigned ExtW      = ExtLen * ByteW;
  localparam int unsigned CaseW     = 5;
  localparam int unsigned OutFieldW = 1 + BaseW + ExtW + CaseW;
  localparam int unsigned OutDataW  = ((OutFieldW + 7) / 8) * 8;

  localparam logic [ByteW-1:0] SpaceChar = 8'h20;
  localparam logic [ByteW-1:0] DotChar   = 8'h2E;
  localparam logic [BaseW-1:0] BaseSpaces = {BaseLen{SpaceChar}};
  localparam logic [ExtW-1:0]  ExtSpaces  = {ExtLen{SpaceChar}};

  localparam logic [CaseW-1:0] LcaseBase = 5'h08;
  localparam logic [CaseW-1:0] LcaseExt  = 5'h10;

  localparam logic [3:0] BaseCountSat = 4'd9;
  localparam logic [2:0] ExtCountSat  = 3'd4;

  typedef struct packed {
    logic             ok;
    logic             lower;
    logic             upper;
    logic [ByteW-1:0] ch;
  } char_class_t;

  // Uppercases letters and flags bytes outside the allowed set for the part.
  function automatic char_class_t classify(input logic [ByteW-1:0] c, input logic is_base);
    char_class_t r;
    r.ok    = 1'b0;
    r.lower = 1'b0;
    r.upper = 1'b0;
    r.ch    = c;
    if (c >= 8'h61 && c <= 8'h7A) begin
      r.ok    = 1'b1;
      r.lower = 1'b1;
      r.ch    = c - 8'h20;
    end else if (c >= 8'h41 && c <= 8'h5A) begin
      r.ok    = 1'b1;
      r.upper = 1'b1;
    end else if ((c >= 8'h30 && c <= 8'h39) || c == 8'h5F || c == 8'h2D) begin
      r.ok = 1'b1;
    end else if (is_base && (c == 8'h7E || c == 8'h21 || c == 8'h23 || c == 8'h24)) begin
      r.ok = 1'b1;
    end
    return r;
  endfunction

endpackage

FILE: rtl/short_name_validator_top.sv
// Channel   Direction  tdata fields (low bit up)                     tlast
// s_axis    in         name_byte[7:0]                                final_byte
// m_axis    out        is_clean, base_text[63:0], ext_text[23:0],    -
//                      case_bits[4:0], two zero pad bits
// One name byte is taken every cycle while the result register is free or being emptied.
// A result is registered from the byte that ends the name and shows in the cycle after it; other bytes give no result.
// The result register is the only storage on the output path, so a stalled output holds
// the input side only when a result is waiting and not taken.
// Reset clears the name state to empty with space-filled buffers and drops the output valid.
module short_name_validator_top
  import sname_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid_i,
  output logic                s_axis_tready_o,
  input  logic [ByteW-1:0]    s_axis_tdata_i,   // name_byte
  input  logic                s_axis_tlast_i,   // final_byte
  output logic                m_axis_tvalid_o,
  input  logic                m_axis_tready_i,
  output logic [OutDataW-1:0] m_axis_tdata_o    // is_clean, base_text, ext_text, case_bits
);

  logic [3:0]       base_count_q, base_count_d;
  logic [2:0]       ext_count_q, ext_count_d;
  logic             dot_seen_q, dot_seen_d;
  logic             base_lo_q, base_lo_d, base_up_q, base_up_d;
  logic             ext_lo_q, ext_lo_d, ext_up_q, ext_up_d;
  logic             rejected_q, rejected_d;
  logic [BaseW-1:0] base_buf_q, base_buf_d;
  logic [ExtW-1:0]  ext_buf_q, ext_buf_d;

  logic                out_valid_q, out_valid_d;
  logic [OutDataW-1:0] out_data_q, out_data_d;

  logic        in_fire;
  logic        out_fire;
  char_class_t cls;
  logic        name_ok;
  logic [CaseW-1:0] case_bits;

  assign s_axis_tready_o = !out_valid_q || m_axis_tready_i;
  assign in_fire  = s_axis_tvalid_i && s_axis_tready_o;
  assign out_fire = out_valid_q && m_axis_tready_i;

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;

  assign cls = classify(s_axis_tdata_i, !dot_seen_q);

  always_comb begin
    base_count_d = base_count_q;
    ext_count_d  = ext_count_q;
    dot_seen_d   = dot_seen_q;
    base_lo_d    = base_lo_q;
    base_up_d    = base_up_q;
    ext_lo_d     = ext_lo_q;
    ext_up_d     = ext_up_q;
    rejected_d   = rejected_q;
    base_buf_d   = base_buf_q;
    ext_buf_d    = ext_buf_q;

    if (s_axis_tdata_i == DotChar) begin
      if (dot_seen_q || base_count_q == 4'd0) begin
        rejected_d = 1'b1;
      end
      dot_seen_d = 1'b1;
    end else if (!dot_seen_q) begin
      base_lo_d = base_lo_q | cls.lower;
      base_up_d = base_up_q | cls.upper;
      if (!cls.ok) begin
        rejected_d = 1'b1;
      end
      if (base_count_q >= 4'd8) begin
        rejected_d   = 1'b1;
        base_count_d = BaseCountSat;
      end else begin
        if (cls.ok) begin
          base_buf_d[base_count_q[2:0]*ByteW +: ByteW] = cls.ch;
        end
        base_count_d = base_count_q + 4'd1;
      end
    end else begin
      ext_lo_d = ext_lo_q | cls.lower;
      ext_up_d = ext_up_q | cls.upper;
      if (!cls.ok) begin
        rejected_d = 1'b1;
      end
      if (ext_count_q >= 3'd3) begin
        rejected_d  = 1'b1;
        ext_count_d = ExtCountSat;
      end else begin
        if (cls.ok) begin
          ext_buf_d[ext_count_q[1:0]*ByteW +: ByteW] = cls.ch;
        end
        ext_count_d = ext_count_q + 3'd1;
      end
    end
  end

  assign name_ok = !rejected_d && base_count_d >= 4'd1 && base_count_d <= 4'd8 &&
                   ext_count_d <= 3'd3 && !(base_lo_d && base_up_d) &&
                   !(ext_lo_d && ext_up_d);
  assign case_bits = (base_lo_d ? LcaseBase : '0) | (ext_lo_d ? LcaseExt : '0);

  always_comb begin
    out_valid_d = out_valid_q && !out_fire;
    out_data_d  = out_data_q;
    if (in_fire && s_axis_tlast_i) begin
      out_valid_d = 1'b1;
      if (name_ok) begin
        out_data_d = {2'b00, case_bits, ext_buf_d, base_buf_d, 1'b1};
      end else begin
        out_data_d = {2'b00, {CaseW{1'b0}}, ExtSpaces, BaseSpaces, 1'b0};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_count_q <= '0;
      ext_count_q  <= '0;
      dot_seen_q   <= 1'b0;
      base_lo_q    <= 1'b0;
      base_up_q    <= 1'b0;
      ext_lo_q     <= 1'b0;
      ext_up_q     <= 1'b0;
      rejected_q   <= 1'b0;
      base_buf_q   <= BaseSpaces;
      ext_buf_q    <= ExtSpaces;
      out_valid_q  <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      if (in_fire) begin
        if (s_axis_tlast_i) begin
          base_count_q <= '0;
          ext_count_q  <= '0;
          dot_seen_q   <= 1'b0;
          base_lo_q    <= 1'b0;
          base_up_q    <= 1'b0;
          ext_lo_q     <= 1'b0;
          ext_up_q     <= 1'b0;
          rejected_q   <= 1'b0;
          base_buf_q   <= BaseSpaces;
          ext_buf_q    <= ExtSpaces;
        end else begin
          base_count_q <= base_count_d;
          ext_count_q  <= ext_count_d;
          dot_seen_q   <= dot_seen_d;
          base_lo_q    <= base_lo_d;
          base_up_q    <= base_up_d;
          ext_lo_q     <= ext_lo_d;
          ext_up_q     <= ext_up_d;
          rejected_q   <= rejected_d;
          base_buf_q   <= base_buf_d;
          ext_buf_q    <= ext_buf_d;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    out_data_q <= out_data_d;
  end

  a_state_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && s_axis_tlast_i) |=> (base_count_q == 4'd0 && ext_count_q == 3'd0 &&
                                     !dot_seen_q && !rejected_q))
    else $error("name state not cleared after the last word");

  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    base_count_q <= BaseCountSat && ext_count_q <= ExtCountSat)
    else $error("part counter beyond saturation");

  a_ext_needs_dot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ext_count_q != 3'd0) |-> dot_seen_q)
    else $error("extension counted without a dot");

  a_bad_blank: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_data_q[0]) |->
      (out_data_q[BaseW+ExtW+CaseW:1] == {{CaseW{1'b0}}, ExtSpaces, BaseSpaces}))
    else $error("rejected name carries text or case bits");

  a_result_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ($rose(out_valid_q)) |-> $past(in_fire && s_axis_tlast_i))
    else $error("result without a last word");

endmodule

FILE: dv/testbench.sv
module testbench;
  import sname_pkg::*;

  localparam int unsigned ClkHalf     = 6;
  localparam int unsigned LimitCycles = 200000;
  localparam int unsigned HoldCycles  = 400;

  typedef logic [ByteW-1:0] name_t[$];

  typedef struct packed {
    logic [CaseW-1:0] case_bits;
    logic [ExtW-1:0]  ext_text;
    logic [BaseW-1:0] base_text;
    logic             is_clean;
  } short_name_t;

  typedef enum int {
    FlawNone,
    FlawSecondDot,
    FlawLeadingDot,
    FlawLongBase,
    FlawLongExt,
    FlawMixedCase,
    FlawBadByte,
    FlawNoise
  } flaw_e;

  logic                clk     = 1'b0;
  logic                rst_n   = 1'b0;
  logic                s_valid = 1'b0;
  logic                s_ready;
  logic [ByteW-1:0]    s_data  = '0;
  logic                s_last  = 1'b0;
  logic                m_valid;
  logic                m_ready = 1'b0;
  logic [OutDataW-1:0] m_data;

  int unsigned tx_idle_pct  = 0;
  int unsigned rx_stall_pct = 0;
  int unsigned hold_left    = 0;
  int unsigned bytes_sent   = 0;
  int unsigned names_checked = 0;
  int unsigned clean_seen   = 0;
  int unsigned fail_count   = 0;

  short_name_t name_results_q[$];

  int unsigned      nm_base_cnt;
  int unsigned      nm_ext_cnt;
  bit               nm_dot;
  bit               nm_base_lo;
  bit               nm_base_up;
  bit               nm_ext_lo;
  bit               nm_ext_up;
  bit               nm_bad;
  logic [BaseW-1:0] nm_base_buf = BaseSpaces;
  logic [ExtW-1:0]  nm_ext_buf  = ExtSpaces;

  short_name_validator_top u_top (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .s_axis_tvalid_i (s_valid),
    .s_axis_tready_o (s_ready),
    .s_axis_tdata_i  (s_data),
    .s_axis_tlast_i  (s_last),
    .m_axis_tvalid_o (m_valid),
    .m_axis_tready_i (m_ready),
    .m_axis_tdata_o  (m_data)
  );

  initial begin
    forever #(ClkHalf) clk = ~clk;
  end

  initial begin
    #(LimitCycles * 2 * ClkHalf);
    $display("Verification failed");
    $finish;
  end

  function automatic void clear_name_state();
    nm_base_cnt = 0;
    nm_ext_cnt  = 0;
    nm_dot      = 1'b0;
    nm_base_lo  = 1'b0;
    nm_base_up  = 1'b0;
    nm_ext_lo   = 1'b0;
    nm_ext_up   = 1'b0;
    nm_bad      = 1'b0;
    nm_base_buf = BaseSpaces;
    nm_ext_buf  = ExtSpaces;
  endfunction

  // Bit 8 says whether the byte may stand in the part; bits 7:0 hold it uppercased.
  function automatic logic [8:0] fold_char(input logic [7:0] c, input bit in_base);
    if (c >= "a" && c <= "z") return {1'b1, c - 8'h20};
    if (c >= "A" && c <= "Z") return {1'b1, c};
    if ((c >= "0" && c <= "9") || c == "_" || c == "-") return {1'b1, c};
    if (in_base && (c == "~" || c == "!" || c == "#" || c == "$")) return {1'b1, c};
    return {1'b0, c};
  endfunction

  task automatic predict_name_byte(input logic [7:0] c, input logic last);
    logic [8:0]  code;
    short_name_t res;
    if (c == DotChar) begin
      if (nm_dot || nm_base_cnt == 0) nm_bad = 1'b1;
      nm_dot = 1'b1;
    end else if (!nm_dot) begin
      code = fold_char(c, 1'b1);
      if (c >= "a" && c <= "z") nm_base_lo = 1'b1;
      if (c >= "A" && c <= "Z") nm_base_up = 1'b1;
      if (!code[8]) nm_bad = 1'b1;
      if (nm_base_cnt >= BaseLen) begin
        nm_bad      = 1'b1;
        nm_base_cnt = BaseLen + 1;
      end else begin
        if (code[8]) nm_base_buf[nm_base_cnt*8 +: 8] = code[7:0];
        nm_base_cnt++;
      end
    end else begin
      code = fold_char(c, 1'b0);
      if (c >= "a" && c <= "z") nm_ext_lo = 1'b1;
      if (c >= "A" && c <= "Z") nm_ext_up = 1'b1;
      if (!code[8]) nm_bad = 1'b1;
      if (nm_ext_cnt >= ExtLen) begin
        nm_bad     = 1'b1;
        nm_ext_cnt = ExtLen + 1;
      end else begin
        if (code[8]) nm_ext_buf[nm_ext_cnt*8 +: 8] = code[7:0];
        nm_ext_cnt++;
      end
    end
    if (last) begin
      res.is_clean = !nm_bad && nm_base_cnt >= 1 && nm_base_cnt <= BaseLen &&
                     nm_ext_cnt <= ExtLen && !(nm_base_lo && nm_base_up) &&
                     !(nm_ext_lo && nm_ext_up);
      if (res.is_clean) begin
        res.base_text = nm_base_buf;
        res.ext_text  = nm_ext_buf;
        res.case_bits = (nm_base_lo ? LcaseBase : '0) | (nm_ext_lo ? LcaseExt : '0);
      end else begin
        res.base_text = BaseSpaces;
        res.ext_text  = ExtSpaces;
        res.case_bits = '0;
      end
      name_results_q.push_back(res);
      clear_name_state();
    end
  endtask

  task automatic send_byte(input logic [7:0] b, input logic last);
    while ($urandom_range(99) < tx_idle_pct) begin
      s_valid <= 1'b0;
      s_data  <= 8'($urandom_range(255));
      s_last  <= 1'($urandom_range(1));
      @(posedge clk);
    end
    s_valid <= 1'b1;
    s_data  <= b;
    s_last  <= last;
    @(posedge clk);
    while (!s_ready) @(posedge clk);
    predict_name_byte(b, last);
    bytes_sent++;
  endtask

  task automatic send_name(input name_t n);
    for (int i = 0; i < n.size(); i++) send_byte(n[i], i == n.size() - 1);
  endtask

  function automatic name_t from_text(input string s);
    name_t q;
    for (int i = 0; i < s.len(); i++) q.push_back(s[i]);
    return q;
  endfunction

  // Mode 0 gives lowercase letters, 1 uppercase, 2 no letters at all.
  function automatic logic [7:0] pick_char(input bit in_base, input int unsigned mode);
    logic [7:0]  base_syms[6] = '{"_", "-", "~", "!", "#", "$"};
    int unsigned r;
    r = $urandom_range(9);
    if (mode != 2 && r < 6) return 8'((mode == 0 ? "a" : "A") + $urandom_range(25));
    if (r < 8 || mode == 2 && r < 5) return 8'("0" + $urandom_range(9));
    if (in_base) return base_syms[$urandom_range(5)];
    return base_syms[$urandom_range(1)];
  endfunction

  function automatic name_t make_name(input flaw_e flaw);
    name_t       q;
    int unsigned base_n;
    int unsigned ext_n;
    int unsigned bmode;
    int unsigned emode;
    int unsigned len;
    bit          dot;
    base_n = $urandom_range(1, BaseLen);
    ext_n  = $urandom_range(0, ExtLen);
    dot    = $urandom_range(99) < 70;
    bmode  = $urandom_range(2);
    emode  = $urandom_range(2);
    case (flaw)
      FlawLongBase: base_n = $urandom_range(BaseLen + 1, BaseLen + 5);
      FlawLongExt: begin
        dot   = 1'b1;
        ext_n = $urandom_range(ExtLen + 1, ExtLen + 3);
      end
      FlawSecondDot: dot = 1'b1;
      FlawMixedCase: begin
        dot = 1'b1;
        if (base_n < 2) base_n = 2;
        if (ext_n < 2) ext_n = 2;
      end
      default: ;
    endcase
    if (flaw == FlawNoise) begin
      len = $urandom_range(1, 12);
      repeat (len) q.push_back($urandom_range(4) == 0 ? DotChar : 8'($urandom_range(255)));
      return q;
    end
    repeat (base_n) q.push_back(pick_char(1'b1, bmode));
    if (dot) begin
      q.push_back(DotChar);
      repeat (ext_n) q.push_back(pick_char(1'b0, emode));
    end
    case (flaw)
      FlawSecondDot: q.insert($urandom_range(1, q.size()), DotChar);
      FlawLeadingDot: q.push_front(DotChar);
      FlawMixedCase: begin
        if ($urandom_range(1)) begin
          q[0] = 8'("a" + $urandom_range(25));
          q[1] = 8'("A" + $urandom_range(25));
        end else begin
          q[base_n + 1] = 8'("A" + $urandom_range(25));
          q[base_n + 2] = 8'("a" + $urandom_range(25));
        end
      end
      FlawBadByte: q[$urandom_range(q.size() - 1)] = 8'($urandom_range(255));
      default: ;
    endcase
    return q;
  endfunction

  task automatic test_directed_names();
    name_t one;
    tx_idle_pct  = 0;
    rx_stall_pct = 0;
    send_name(from_text("a.b"));
    send_name(from_text("A."));
    send_name(from_text(".B"));
    send_name(from_text("A.."));
    one = '{8'hFF};
    send_name(one);
    one = '{8'h00};
    send_name(one);
    send_name(from_text("aB"));
    send_name(from_text("~.~"));
    send_name(from_text("12345678Z"));
  endtask

  task automatic test_random_names(input int unsigned tx_pct, input int unsigned rx_pct,
                                   input int unsigned byte_budget);
    int unsigned stop_at;
    flaw_e       flaw;
    tx_idle_pct  = tx_pct;
    rx_stall_pct = rx_pct;
    stop_at      = bytes_sent + byte_budget;
    while (bytes_sent < stop_at) begin
      if ($urandom_range(99) < 60) flaw = FlawNone;
      else flaw = flaw_e'($urandom_range(int'(FlawSecondDot), int'(FlawNoise)));
      send_name(make_name(flaw));
    end
  endtask

  // The output side stops for a long stretch while names keep coming, so the
  // single result register fills and the input must stall.
  task automatic test_output_hold();
    tx_idle_pct  = 0;
    rx_stall_pct = 0;
    hold_left   <= HoldCycles;
    repeat (12) send_name(make_name(FlawNone));
  endtask

  always @(posedge clk) begin
    if (hold_left != 0) begin
      m_ready   <= 1'b0;
      hold_left <= hold_left - 1;
    end else begin
      m_ready <= ($urandom_range(99) >= rx_stall_pct);
    end
  end

  always @(posedge clk) begin : check_result
    short_name_t got;
    short_name_t want;
    if (rst_n && m_valid && m_ready) begin
      got = m_data[$bits(short_name_t)-1:0];
      if (name_results_q.size() == 0) begin
        $error("Result word %h arrived with no name pending.", got);
        fail_count++;
      end else begin
        want = name_results_q.pop_front();
        if (got.is_clean !== want.is_clean) begin
          $error("is_clean: expected %0b, actual %0b", want.is_clean, got.is_clean);
          fail_count++;
        end
        if (got.base_text !== want.base_text) begin
          $error("base_text: expected %h, actual %h", want.base_text, got.base_text);
          fail_count++;
        end
        if (got.ext_text !== want.ext_text) begin
          $error("ext_text: expected %h, actual %h", want.ext_text, got.ext_text);
          fail_count++;
        end
        if (got.case_bits !== want.case_bits) begin
          $error("case_bits: expected %h, actual %h", want.case_bits, got.case_bits);
          fail_count++;
        end
        names_checked++;
        if (want.is_clean) clean_seen++;
      end
    end
  end

  initial begin
    clear_name_state();
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    test_directed_names();
    test_random_names(0, 0, 160);
    test_random_names(86, 0, 160);
    test_random_names(0, 86, 160);
    test_random_names(32, 32, 160);
    test_output_hold();
    s_valid <= 1'b0;
    while (name_results_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    $display("Checked %0d name results (%0d clean) from %0d name bytes.",
             names_checked, clean_seen, bytes_sent);
    $display("Covered corner names, four idle mixes and a long output hold.");
    if (fail_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
